>>> design/slce_pkg.sv
// ----------------------------------------------------------------------------
// slce_pkg
// Shared types and constants for the stuffed, checksummed line encoder.
// ----------------------------------------------------------------------------
package slce_pkg;

   localparam logic [15:0] CRC_POLY    = 16'h8408;
   localparam logic [7:0]  FLAG_BYTE   = 8'h7E;
   localparam logic [2:0]  STUFF_LIMIT = 3'd5;

   typedef enum logic [1:0] {
      CMD_START    = 2'd0,
      CMD_DATA     = 2'd1,
      CMD_CHECKSUM = 2'd2,
      CMD_CLOSE    = 2'd3
   } command_type;

   typedef enum logic [2:0] {
      PK_NONE   = 3'd0,
      PK_CLEAR  = 3'd1,
      PK_BIT    = 3'd2,
      PK_PAD    = 3'd3,
      PK_FINISH = 3'd4
   } pk_op_type;

   typedef struct packed {
      pk_op_type op;
      logic      bit_one;
      logic      close;
   } pk_ctl_type;

   typedef struct packed {
      logic clear;
      logic step;
      logic bit_in;
   } crc_ctl_type;

endpackage

>>> design/slce_crc.sv
// ----------------------------------------------------------------------------
// slce_crc
// Bit-serial reflected crc-16 register, one data bit per step, lsb first.
// ----------------------------------------------------------------------------
module slce_crc
   import slce_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_ctl_type crc_ctl,
   output logic [15:0] check_value
);

   logic [15:0] check_ff;
   logic [15:0] check_in;

   always_comb begin
      check_in = check_ff;
      if (crc_ctl.clear) begin
         check_in = '0;
      end else if (crc_ctl.step) begin
         check_in = {1'b0, check_ff[15:1]} ^
                    ((check_ff[0] ^ crc_ctl.bit_in) ? CRC_POLY : 16'h0000);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= '0;
      end else begin
         check_ff <= check_in;
      end
   end

   assign check_value = check_ff;

endmodule

>>> design/slce_packer.sv
// ----------------------------------------------------------------------------
// slce_packer
// Turns line bits into symbols, packs them into line bytes and holds the
// newest byte back until it is known whether it ends the request.
// ----------------------------------------------------------------------------
module slce_packer
   import slce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pk_ctl_type pk_ctl,
   output logic       pk_go,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_last_of_item,
   output logic       rsp_frame_done
);

   logic [7:0] shift_ff, shift_in;
   logic [2:0] count_ff, count_in;
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff, hold_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_done_ff, out_done_in;

   logic [7:0] bit_shift;
   logic [2:0] bit_count;
   logic       bit_emit;
   logic [7:0] bit_byte;
   logic [3:0] pad_n;
   logic [7:0] pad_byte;
   logic       emit;
   logic [7:0] emit_byte;
   logic       need_out;
   logic       out_free;

   // up to three symbols per line bit
   always_comb begin
      logic       act;
      logic       sym;
      bit_shift = shift_ff;
      bit_count = count_ff;
      bit_emit  = 1'b0;
      bit_byte  = shift_ff;
      for (int j = 0; j < 3; j++) begin
         act = (j != 2) || pk_ctl.bit_one;
         sym = (j == 2) || ((j == 1) && !pk_ctl.bit_one);
         if (act) begin
            bit_shift = {sym, bit_shift[7:1]};
            if (bit_count == 3'd7) begin
               bit_emit  = 1'b1;
               bit_byte  = bit_shift;
               bit_count = 3'd0;
            end else begin
               bit_count = bit_count + 3'd1;
            end
         end
      end
   end

   assign pad_n    = 4'd8 - {1'b0, count_ff};
   assign pad_byte = (shift_ff >> pad_n) | ~(8'hFF >> pad_n);

   always_comb begin
      emit      = 1'b0;
      emit_byte = bit_byte;
      case (pk_ctl.op)
         PK_BIT: begin
            emit = bit_emit;
         end
         PK_PAD: begin
            emit      = (count_ff != 3'd0);
            emit_byte = pad_byte;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign need_out = (pk_ctl.op == PK_FINISH) ? hold_valid_ff : (emit && hold_valid_ff);
   assign pk_go    = !need_out || out_free;

   always_comb begin
      shift_in      = shift_ff;
      count_in      = count_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      if (pk_go) begin
         if (need_out) begin
            out_valid_in = 1'b1;
            out_byte_in  = hold_byte_ff;
            out_last_in  = (pk_ctl.op == PK_FINISH);
            out_done_in  = (pk_ctl.op == PK_FINISH) && pk_ctl.close;
         end
         case (pk_ctl.op)
            PK_CLEAR: begin
               shift_in      = '0;
               count_in      = '0;
               hold_valid_in = 1'b0;
            end
            PK_BIT: begin
               shift_in = bit_shift;
               count_in = bit_count;
            end
            PK_PAD: begin
               if (count_ff != 3'd0) begin
                  shift_in = pad_byte;
                  count_in = 3'd0;
               end
            end
            PK_FINISH: begin
               hold_valid_in = 1'b0;
            end
            default: begin
               shift_in = shift_ff;
            end
         endcase
         if (emit) begin
            hold_valid_in = 1'b1;
            hold_byte_in  = emit_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff      <= '0;
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         shift_ff      <= shift_in;
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_done_ff  <= out_done_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_byte    = out_byte_ff;
   assign rsp_last_of_item = out_last_ff;
   assign rsp_frame_done   = out_done_ff;

endmodule

>>> design/stuffed_crc_line_encoder.sv
// ----------------------------------------------------------------------------
// stuffed_crc_line_encoder
// Bit-stuffing crc-16 line encoder: one line bit per cycle unless rsp stalls.
//
//   channel  direction  ports
//   req      in         req_valid, req_stall, req_command, req_data_byte
//   rsp      out        rsp_valid, rsp_stall, rsp_line_byte,
//                       rsp_last_of_item, rsp_frame_done
//
// a request is taken while idle; the sequencer then sends each line bit
// (stuffed bits included), pads the last line byte on close and finishes.
// req_stall is high whenever a request is in work; synchronous reset.
// a stalled rsp holds the sequencer only when a finished line byte must move.
// ----------------------------------------------------------------------------
module stuffed_crc_line_encoder
   import slce_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_last_of_item,
   output logic       rsp_frame_done
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_FLAG   = 6'b000010,
      ST_DATA   = 6'b000100,
      ST_STUFF  = 6'b001000,
      ST_PAD    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   command_type cmd_ff, cmd_in;
   logic [2:0]  idx_ff, idx_in;
   logic [2:0]  ones_ff, ones_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  high_ff, high_in;
   logic        second_ff, second_in;

   pk_ctl_type  pk_ctl;
   crc_ctl_type crc_ctl;
   logic        pk_go;
   logic [15:0] check_value;
   logic        accept;
   logic        data_bit;
   logic [2:0]  ones_next;
   logic        stuff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign data_bit  = byte_ff[3'd7 - idx_ff];
   assign ones_next = data_bit ? (ones_ff + 3'd1) : 3'd0;
   assign stuff     = data_bit && (ones_next >= STUFF_LIMIT);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      ones_in   = ones_ff;
      byte_in   = byte_ff;
      high_in   = high_ff;
      second_in = second_ff;
      pk_ctl.op      = PK_NONE;
      pk_ctl.bit_one = 1'b0;
      pk_ctl.close   = (cmd_ff == CMD_CLOSE);
      crc_ctl.clear  = 1'b0;
      crc_ctl.step   = 1'b0;
      crc_ctl.bit_in = byte_ff[idx_ff];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in    = command_type'(req_command);
               idx_in    = 3'd0;
               second_in = 1'b0;
               case (command_type'(req_command))
                  CMD_START: begin
                     pk_ctl.op     = PK_CLEAR;
                     crc_ctl.clear = 1'b1;
                     ones_in       = 3'd0;
                     state_in      = ST_FLAG;
                  end
                  CMD_DATA: begin
                     byte_in  = req_data_byte;
                     state_in = ST_DATA;
                  end
                  CMD_CHECKSUM: begin
                     byte_in  = check_value[7:0];
                     high_in  = check_value[15:8];
                     state_in = ST_DATA;
                  end
                  default: begin
                     state_in = ST_FLAG;
                  end
               endcase
            end
         end
         ST_FLAG: begin
            pk_ctl.op      = PK_BIT;
            pk_ctl.bit_one = FLAG_BYTE[3'd7 - idx_ff];
            if (pk_go) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_in = (cmd_ff == CMD_CLOSE) ? ST_PAD : ST_FINISH;
               end
            end
         end
         ST_DATA: begin
            pk_ctl.op      = PK_BIT;
            pk_ctl.bit_one = data_bit;
            crc_ctl.step   = pk_go;
            if (pk_go) begin
               ones_in = stuff ? 3'd0 : ones_next;
               if (stuff) begin
                  state_in = ST_STUFF;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     if ((cmd_ff == CMD_CHECKSUM) && !second_ff) begin
                        byte_in   = high_ff;
                        second_in = 1'b1;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
               end
            end
         end
         ST_STUFF: begin
            pk_ctl.op      = PK_BIT;
            pk_ctl.bit_one = 1'b0;
            if (pk_go) begin
               idx_in   = idx_ff + 3'd1;
               state_in = ST_DATA;
               if (idx_ff == 3'd7) begin
                  if ((cmd_ff == CMD_CHECKSUM) && !second_ff) begin
                     byte_in   = high_ff;
                     second_in = 1'b1;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_PAD: begin
            pk_ctl.op = PK_PAD;
            if (pk_go) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            pk_ctl.op = PK_FINISH;
            if (pk_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ones_ff   <= '0;
         idx_ff    <= '0;
         second_ff <= 1'b0;
         cmd_ff    <= CMD_START;
      end else begin
         state_ff  <= state_in;
         ones_ff   <= ones_in;
         idx_ff    <= idx_in;
         second_ff <= second_in;
         cmd_ff    <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      high_ff <= high_in;
   end

   slce_crc u_crc (
      .clock       (clock),
      .reset       (reset),
      .crc_ctl     (crc_ctl),
      .check_value (check_value)
   );

   slce_packer u_packer (
      .clock            (clock),
      .reset            (reset),
      .pk_ctl           (pk_ctl),
      .pk_go            (pk_go),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_done   (rsp_frame_done)
   );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stuffed_crc_line_encoder. Requests are queued by a
// stimulus block and presented by a clocked driver with random gaps; a
// clocked monitor checks every line byte against an in-bench encoder model
// that tracks the crc, the run of ones for bit stuffing and the symbol packer.
// Directed frames cover flags, stuffing, checksum, start with pending symbols
// and close on a full line byte; random frames follow, mostly well formed,
// with a long receiver hold-off and a stretch without any idling.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import slce_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = 40;
   localparam int LONG_HOLD_CYCLES = 160;

   typedef struct {
      command_type cmd;
      logic [7:0]  data;
   } request_type;

   typedef struct {
      logic [7:0] line_byte;
      logic       last_of_item;
      logic       frame_done;
   } line_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = CMD_START;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_line_byte;
   logic       rsp_last_of_item;
   logic       rsp_frame_done;

   request_type   request_q[$];
   line_word_type line_expect_q[$];

   logic [7:0]  enc_shift = 8'h00;
   logic [2:0]  enc_count = 3'd0;
   logic [2:0]  enc_ones = 3'd0;
   logic [15:0] enc_crc = 16'h0000;
   logic [7:0]  packed_bytes[$];

   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;
   logic calm = 1'b0;
   logic hold_request = 1'b0;
   logic hold_started = 1'b0;
   int   req_wait = 0;
   int   rsp_wait = 0;
   int   hold_left = 0;
   int   cycles = 0;
   int   errors = 0;
   int   requests_done = 0;
   int   frames_closed = 0;
   int   checksums_sent = 0;
   int   line_bytes_seen = 0;

   stuffed_crc_line_encoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_byte    (rsp_line_byte),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_frame_done   (rsp_frame_done)
   );

   always #4 clock = ~clock;

   function automatic void push_symbol(input logic sym);
      enc_shift = {sym, enc_shift[7:1]};
      enc_count = enc_count + 3'd1;
      if (enc_count == 3'd0) begin
         packed_bytes.push_back(enc_shift);
      end
   endfunction

   function automatic void push_line_bit(input logic one);
      push_symbol(1'b0);
      if (one) begin
         push_symbol(1'b0);
      end
      push_symbol(1'b1);
   endfunction

   function automatic void send_flag();
      for (int i = 7; i >= 0; i--) begin
         push_line_bit(FLAG_BYTE[i]);
      end
   endfunction

   function automatic void send_payload_byte(input logic [7:0] b);
      logic [15:0] c;
      c = enc_crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      enc_crc = c;
      for (int i = 7; i >= 0; i--) begin
         if (b[i]) begin
            enc_ones = enc_ones + 3'd1;
            push_line_bit(1'b1);
            if (enc_ones >= STUFF_LIMIT) begin
               enc_ones = 3'd0;
               push_line_bit(1'b0);
            end
         end else begin
            enc_ones = 3'd0;
            push_line_bit(1'b0);
         end
      end
   endfunction

   function automatic void encode_request(input command_type cmd, input logic [7:0] data);
      logic [15:0]   snap;
      line_word_type word;
      packed_bytes.delete();
      case (cmd)
         CMD_START: begin
            enc_shift = 8'h00;
            enc_count = 3'd0;
            enc_ones  = 3'd0;
            enc_crc   = 16'h0000;
            send_flag();
         end
         CMD_DATA: begin
            send_payload_byte(data);
         end
         CMD_CHECKSUM: begin
            snap = enc_crc;
            send_payload_byte(snap[7:0]);
            send_payload_byte(snap[15:8]);
         end
         default: begin
            send_flag();
            while (enc_count != 3'd0) begin
               push_symbol(1'b1);
            end
         end
      endcase
      foreach (packed_bytes[i]) begin
         word.line_byte    = packed_bytes[i];
         word.last_of_item = (i == packed_bytes.size() - 1);
         word.frame_done   = word.last_of_item && (cmd == CMD_CLOSE);
         line_expect_q.push_back(word);
      end
   endfunction

   // request driver
   always @(negedge clock) begin
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_wait > 0) begin
            req_wait--;
            req_valid <= 1'b0;
         end else if (request_q.size() > 0) begin
            nxt = request_q.pop_front();
            req_valid     <= 1'b1;
            req_command   <= nxt.cmd;
            req_data_byte <= nxt.data;
            req_wait = calm ? 0 : $urandom_range(0, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // line byte receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_started) begin
            hold_started = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (rsp_taken) begin
            rsp_wait = calm ? 0 : $urandom_range(0, 6);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // request tracking and line byte checking
   always @(posedge clock) begin
      line_word_type want;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         cycles++;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            requests_done++;
            if (command_type'(req_command) == CMD_CLOSE) frames_closed++;
            if (command_type'(req_command) == CMD_CHECKSUM) checksums_sent++;
            encode_request(command_type'(req_command), req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            line_bytes_seen++;
            if (line_expect_q.size() == 0) begin
               $error("unexpected line byte %02h", rsp_line_byte);
               errors++;
            end else begin
               want = line_expect_q.pop_front();
               if (rsp_line_byte !== want.line_byte) begin
                  $error("line_byte: expected %02h, got %02h", want.line_byte, rsp_line_byte);
                  errors++;
               end
               if (rsp_last_of_item !== want.last_of_item) begin
                  $error("last_of_item: expected %0b, got %0b",
                         want.last_of_item, rsp_last_of_item);
                  errors++;
               end
               if (rsp_frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0b, got %0b", want.frame_done, rsp_frame_done);
                  errors++;
               end
            end
         end
         if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic add_request(input command_type cmd, input logic [7:0] data);
      request_type r;
      r.cmd  = cmd;
      r.data = data;
      request_q.push_back(r);
   endtask

   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 7))
         0: return 8'hFF;
         1: return 8'h00;
         2: return 8'hFF ^ (8'h01 << $urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed frames with random content, some broken or noisy
   task automatic add_random_frames(input int target);
      int added;
      int n;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 9) == 0) begin
            add_request(command_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            added++;
         end else begin
            add_request(CMD_START, 8'($urandom_range(0, 255)));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               add_request(CMD_DATA, pick_payload());
            end
            added += n + 1;
            if ($urandom_range(0, 7) != 0) begin
               add_request(CMD_CHECKSUM, 8'($urandom_range(0, 255)));
               added++;
            end
            if ($urandom_range(0, 7) != 0) begin
               add_request(CMD_CLOSE, 8'($urandom_range(0, 255)));
               added++;
            end
         end
      end
   endtask

   task automatic wait_idle();
      while (request_q.size() != 0 || req_valid) @(posedge clock);
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // flags, stuffing across byte edges, checksum
      add_request(CMD_START, 8'hFF);
      add_request(CMD_DATA, 8'h00);
      add_request(CMD_DATA, 8'hFF);
      add_request(CMD_DATA, 8'hFF);
      add_request(CMD_DATA, 8'h7E);
      add_request(CMD_DATA, 8'h01);
      add_request(CMD_DATA, 8'h80);
      add_request(CMD_CHECKSUM, 8'hFF);
      add_request(CMD_CLOSE, 8'hFF);
      // close lands on a full line byte, no padding
      add_request(CMD_START, 8'h00);
      add_request(CMD_DATA, 8'hF0);
      add_request(CMD_CLOSE, 8'h00);
      // start drops pending symbols
      add_request(CMD_START, 8'hA5);
      add_request(CMD_DATA, 8'hAA);
      add_request(CMD_DATA, 8'h55);
      add_request(CMD_START, 8'h5A);
      add_request(CMD_DATA, 8'hFF);
      add_request(CMD_CHECKSUM, 8'h00);
      add_request(CMD_CHECKSUM, 8'hFF);
      add_request(CMD_CLOSE, 8'hFF);
      add_request(CMD_CLOSE, 8'h00);
      add_request(CMD_DATA, 8'h3C);
      wait_idle();

      hold_request = 1'b1;
      add_random_frames(50);
      wait_idle();

      calm = 1'b1;
      add_random_frames(25);
      wait_idle();

      calm = 1'b0;
      add_random_frames(35);
      wait_idle();

      $display("run covered %0d requests, %0d checksums and %0d closed frames",
               requests_done, checksums_sent, frames_closed);
      $display("%0d line bytes compared across idle gaps and a long receiver hold-off",
               line_bytes_seen);
      if (errors == 0 && line_expect_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/slce_pkg.sv
design/slce_crc.sv
design/slce_packer.sv
design/stuffed_crc_line_encoder.sv
tb/testbench.sv
